// ===== sv/supersampled_triangle_pixel_shader_unit_macros.svh =====
// Assertion macros shared by the checker of the triangle pixel shader.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef SUPERSAMPLED_TRIANGLE_PIXEL_SHADER_UNIT_MACROS_SVH
`define SUPERSAMPLED_TRIANGLE_PIXEL_SHADER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define STPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define STPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/stps_pkg.sv =====
// Shared types, widths and helpers of the supersampled triangle pixel shader.
// No dependencies; imported by stps_edge, stps_interp and the top level.
package stps_pkg;

  localparam int SCREEN_WIDTH_DEF  = 256;
  localparam int SCREEN_HEIGHT_DEF = 256;

  localparam int STORE_AW    = 16;
  localparam int STORE_DEPTH = 1 << STORE_AW;

  localparam int CW    = 17;        // vertex coordinate
  localparam int ZW    = 16;        // depth code
  localparam int DW    = 18;        // coordinate difference
  localparam int PW    = 2 * DW;    // edge partial product
  localparam int EW    = PW + 1;    // edge value
  localparam int MW    = EW + ZW;   // weighted depth term
  localparam int NW    = MW + 2;    // sum of three terms
  localparam int QW    = ZW;        // interpolated depth quotient
  localparam int TW    = ZW + 2;    // sum of four depths
  localparam int COLW  = 24;
  localparam int NEDGE = 3;
  localparam int NSAMP = 4;

  localparam logic [3:0] OFS_LO = 4'd4;   // 0.25 pixel
  localparam logic [3:0] OFS_HI = 4'd12;  // 0.75 pixel

  localparam logic [ZW-1:0] DEPTH_MAX = 16'hFFFF;

  // floor(t/3) == (t * DIV3_RECIP) >> DIV3_SHIFT for every t below 2^18.
  localparam logic [TW-1:0] DIV3_RECIP = 18'd174763;
  localparam int            DIV3_SHIFT = 19;

  typedef enum logic [1:0] {
    FUNC_LOAD_VERTEX = 2'd0,
    FUNC_LOAD_COLOUR = 2'd1,
    FUNC_SHADE       = 2'd2,
    FUNC_CLEAR       = 2'd3
  } func_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ZW-1:0]        z;
  } vert_t;

  // Side information that travels with every request through the pipeline.
  typedef struct packed {
    logic                valid;
    func_t               func;
    logic [STORE_AW-1:0] idx;
    logic [COLW-1:0]     colour;
  } meta_t;

  function automatic logic [EW-1:0] mag_f(input logic signed [EW-1:0] v);
    return v[EW-1] ? EW'(-v) : EW'(v);
  endfunction

endpackage

// ===== sv/stps_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the depth store.
module stps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/stps_edge.sv =====
// Edge-function pipeline: differences, products, sums, then coverage and magnitudes.
// Four register stages; depends on stps_pkg.
module stps_edge import stps_pkg::*; (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  meta_t                                meta_in,
  input  vert_t [NEDGE-1:0]                    vert,
  input  logic [7:0]                           px,
  input  logic [7:0]                           py,
  output meta_t                                meta_out,
  output logic [NSAMP-1:0]                     cov,
  output logic [NEDGE-1:0][NSAMP-1:0][EW-1:0] mag_e,
  output logic [EW-1:0]                        mag_area,
  output logic [NEDGE-1:0][ZW-1:0]            z_out
);

  logic [11:0] sx [NSAMP];
  logic [11:0] sy [NSAMP];

  meta_t meta1_r, meta2_r, meta3_r, meta4_r;
  logic [NEDGE-1:0][ZW-1:0] z1_r, z2_r, z3_r, z4_r;

  logic signed [DW-1:0] ca1_r [NEDGE];
  logic signed [DW-1:0] cb1_r [NEDGE];
  logic signed [DW-1:0] rx1_r [NEDGE][NSAMP];
  logic signed [DW-1:0] ry1_r [NEDGE][NSAMP];
  logic signed [DW-1:0] arx1_r, ary1_r;
  logic signed [PW-1:0] pa2_r [NEDGE][NSAMP];
  logic signed [PW-1:0] pb2_r [NEDGE][NSAMP];
  logic signed [PW-1:0] aa2_r, ab2_r;
  logic signed [EW-1:0] e3_r [NEDGE][NSAMP];
  logic signed [EW-1:0] area3_r;
  logic [NEDGE-1:0][NSAMP-1:0][EW-1:0] mag4_r;
  logic [EW-1:0]        area4_r;
  logic [NSAMP-1:0]     cov_nxt, cov4_r;

  for (genvar s = 0; s < NSAMP; s++) begin : g_samp
    assign sx[s] = {px, 4'b0000} + ((s % 2) == 1 ? 12'(OFS_HI) : 12'(OFS_LO));
    assign sy[s] = {py, 4'b0000} + ((s / 2) == 1 ? 12'(OFS_HI) : 12'(OFS_LO));
  end

  // Edge g runs from vertex g+1 to vertex g+2, so e0+e1+e2 equals the doubled area.
  for (genvar g = 0; g < NEDGE; g++) begin : g_edge
    localparam int IA = (g + 1) % NEDGE;
    localparam int IB = (g + 2) % NEDGE;

    always_ff @(posedge clk) begin
      if (en) begin
        ca1_r[g] <= DW'($signed(vert[IA].y)) - DW'($signed(vert[IB].y));
        cb1_r[g] <= DW'($signed(vert[IB].x)) - DW'($signed(vert[IA].x));
      end
    end

    for (genvar s = 0; s < NSAMP; s++) begin : g_s
      always_ff @(posedge clk) begin
        if (en) begin
          rx1_r[g][s]  <= DW'(sx[s]) - DW'($signed(vert[IB].x));
          ry1_r[g][s]  <= DW'(sy[s]) - DW'($signed(vert[IB].y));
          pa2_r[g][s]  <= ca1_r[g] * rx1_r[g][s];
          pb2_r[g][s]  <= cb1_r[g] * ry1_r[g][s];
          e3_r[g][s]   <= EW'(pa2_r[g][s]) + EW'(pb2_r[g][s]);
          mag4_r[g][s] <= mag_f(e3_r[g][s]);
        end
      end
    end
  end

  always_comb begin
    logic apos;
    logic aneg;
    logic allpos;
    logic allneg;
    apos = !area3_r[EW-1] && (area3_r != '0);
    aneg = area3_r[EW-1];
    for (int s = 0; s < NSAMP; s++) begin
      allpos = 1'b1;
      allneg = 1'b1;
      for (int g = 0; g < NEDGE; g++) begin
        allpos = allpos && !e3_r[g][s][EW-1];
        allneg = allneg && (e3_r[g][s][EW-1] || (e3_r[g][s] == '0));
      end
      cov_nxt[s] = (apos && allpos) || (aneg && allneg);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NEDGE; g++) begin
        z1_r[g] <= vert[g].z;
      end
      arx1_r  <= DW'($signed(vert[0].x)) - DW'($signed(vert[2].x));
      ary1_r  <= DW'($signed(vert[0].y)) - DW'($signed(vert[2].y));
      aa2_r   <= ca1_r[0] * arx1_r;
      ab2_r   <= cb1_r[0] * ary1_r;
      area3_r <= EW'(aa2_r) + EW'(ab2_r);
      area4_r <= mag_f(area3_r);
      cov4_r  <= cov_nxt;
      z2_r    <= z1_r;
      z3_r    <= z2_r;
      z4_r    <= z3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta1_r <= '0;
      meta2_r <= '0;
      meta3_r <= '0;
      meta4_r <= '0;
    end else if (en) begin
      meta1_r <= meta_in;
      meta2_r <= meta1_r;
      meta3_r <= meta2_r;
      meta4_r <= meta3_r;
    end
  end

  assign meta_out = meta4_r;
  assign cov      = cov4_r;
  assign mag_e    = mag4_r;
  assign mag_area = area4_r;
  assign z_out    = z4_r;

endmodule

// ===== sv/stps_interp.sv =====
// Depth interpolation: weighted depth sums, then a pipelined restoring divider
// that yields one quotient bit per stage for each sample. Depends on stps_pkg.
module stps_interp import stps_pkg::*; (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  meta_t                                meta_in,
  input  logic [NSAMP-1:0]                     cov_in,
  input  logic [NEDGE-1:0][NSAMP-1:0][EW-1:0] mag_e,
  input  logic [EW-1:0]                        mag_area,
  input  logic [NEDGE-1:0][ZW-1:0]            z_in,
  output meta_t                                meta_out,
  output logic [NSAMP-1:0]                     cov_out,
  output logic [NSAMP-1:0][QW-1:0]            quot
);

  logic [MW-1:0]    prod1_r [NEDGE][NSAMP];
  logic [EW-1:0]    den1_r;
  logic [NSAMP-1:0] cov1_r;
  meta_t            meta1_r;

  // Position 0 holds the dividends; position k has quotient bits QW-k and above settled.
  logic [NW-1:0]    rem_p  [QW+1][NSAMP];
  logic [QW-1:0]    q_p    [QW+1][NSAMP];
  logic [EW-1:0]    den_p  [QW+1];
  logic [NSAMP-1:0] cov_p  [QW+1];
  meta_t            meta_p [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NEDGE; g++) begin
        for (int s = 0; s < NSAMP; s++) begin
          prod1_r[g][s] <= MW'(mag_e[g][s]) * MW'(z_in[g]);
        end
      end
      den1_r <= mag_area;
      cov1_r <= cov_in;
      for (int s = 0; s < NSAMP; s++) begin
        rem_p[0][s] <= NW'(prod1_r[0][s]) + NW'(prod1_r[1][s]) + NW'(prod1_r[2][s]);
        q_p[0][s]   <= '0;
      end
      den_p[0] <= den1_r;
      cov_p[0] <= cov1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta1_r   <= '0;
      meta_p[0] <= '0;
    end else if (en) begin
      meta1_r   <= meta_in;
      meta_p[0] <= meta1_r;
    end
  end

  // For a covered sample the weights sum to the area, so the quotient fits in QW bits.
  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int SH = QW - k;

    for (genvar s = 0; s < NSAMP; s++) begin : g_lane
      logic [NW-1:0] trial;
      logic          ge;

      assign trial = NW'(den_p[k-1]) << SH;
      assign ge    = rem_p[k-1][s] >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_p[k][s] <= ge ? rem_p[k-1][s] - trial : rem_p[k-1][s];
          q_p[k][s]   <= q_p[k-1][s] | (ge ? (QW'(1) << SH) : QW'(0));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_p[k] <= den_p[k-1];
        cov_p[k] <= cov_p[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        meta_p[k] <= '0;
      end else if (en) begin
        meta_p[k] <= meta_p[k-1];
      end
    end
  end

  always_comb begin
    for (int s = 0; s < NSAMP; s++) begin
      quot[s] = q_p[QW][s];
    end
  end

  assign meta_out = meta_p[QW];
  assign cov_out  = cov_p[QW];

endmodule

// ===== sv/supersampled_triangle_pixel_shader_unit.sv =====
// Triangle pixel shader with 2x2 supersampling and a 64K-entry depth store.
// Requests arrive on the in_ stream; in_tuser carries the function code
// (load vertex, load colour, shade pixel, clear depth entry). Every request,
// of any kind, yields exactly one result on the out_ stream, in order.
// Loads take effect at acceptance, so the next request already sees them.
// A shade result carries the frame index, the averaged depth, the covered
// sample count, and in out_tuser a write flag with the flat colour.
// One request can enter every cycle while out_tready does not stall the
// pipeline. The pipeline holds the 16-stage quotient divider that runs
// four lanes side by side, plus edge, weighting and depth-test stages.
// The depth store is read one stage ahead of the test and written in the
// test stage; a bypass register covers back-to-back hits on one entry.
// When out_tready is low with a result held, the whole pipeline freezes and
// in_tready drops; nothing is lost or repeated. Synchronous reset clears the
// valid bits, the vertices and the colour; the depth store is not cleared,
// so software clears every entry it will shade before use.
// Depends on stps_pkg, stps_ram, stps_edge and stps_interp.
module supersampled_triangle_pixel_shader_unit import stps_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // vertex_slot, vert_x, vert_y, vert_depth, tri_red, tri_green, tri_blue,
  // pixel_x, pixel_y, zero padding
  input  logic [95:0] in_tdata,
  // func
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // frame_index, out_red, out_green, out_blue, out_depth, covered_samples,
  // zero padding
  output logic [63:0] out_tdata,
  // pixel_write
  output logic [0:0]  out_tuser
);

  logic        in_accept;
  logic        en;
  func_t       in_func;
  logic [1:0]  in_slot;
  logic [7:0]  in_px, in_py;
  logic [31:0] idx_full;
  meta_t       meta_in;

  vert_t [NEDGE-1:0] vert_r;
  logic [COLW-1:0]   colour_r;

  meta_t                               e_meta;
  logic [NSAMP-1:0]                    e_cov;
  logic [NEDGE-1:0][NSAMP-1:0][EW-1:0] e_mag;
  logic [EW-1:0]                       e_area;
  logic [NEDGE-1:0][ZW-1:0]           e_z;

  meta_t                    d_meta;
  logic [NSAMP-1:0]         d_cov;
  logic [NSAMP-1:0][QW-1:0] d_quot;

  logic [TW-1:0]   total_nxt, total1_r, total2_r;
  logic [2:0]      count_nxt, count1_r, count2_r, count3_r;
  meta_t           meta1_r, meta2_r, meta3_r;
  logic [2*TW-1:0] prod3_r;
  logic [ZW-1:0]   avg_nxt, avg3_r;

  logic [ZW-1:0]       ram_rdata;
  logic [ZW-1:0]       old_depth;
  logic                pass;
  logic                wr_req;
  logic                wr_en;
  logic [ZW-1:0]       wr_data;
  logic                byp_valid_r;
  logic [STORE_AW-1:0] byp_addr_r;
  logic [ZW-1:0]       byp_data_r;

  logic                out_valid_r;
  logic                out_write_r;
  logic [STORE_AW-1:0] out_idx_r;
  logic [COLW-1:0]     out_colour_r;
  logic [ZW-1:0]       out_depth_r;
  logic [2:0]          out_count_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign in_accept = in_tvalid && in_tready;

  assign in_func = func_t'(in_tuser);
  assign in_slot = in_tdata[1:0];
  assign in_px   = in_tdata[83:76];
  assign in_py   = in_tdata[91:84];

  // The row flip wraps modulo the store size, like the index itself.
  assign idx_full = (32'(SCREEN_HEIGHT) - 32'd1 - 32'(in_py)) * 32'(SCREEN_WIDTH)
                    + 32'(in_px);

  always_comb begin
    meta_in.valid  = in_tvalid;
    meta_in.func   = in_func;
    meta_in.idx    = idx_full[STORE_AW-1:0];
    meta_in.colour = colour_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vert_r   <= '0;
      colour_r <= '0;
    end else if (in_accept) begin
      case (in_func)
        FUNC_LOAD_VERTEX: begin
          case (in_slot)
            2'd0: vert_r[0] <= {in_tdata[18:2], in_tdata[35:19], in_tdata[51:36]};
            2'd1: vert_r[1] <= {in_tdata[18:2], in_tdata[35:19], in_tdata[51:36]};
            2'd2: vert_r[2] <= {in_tdata[18:2], in_tdata[35:19], in_tdata[51:36]};
            default: ;
          endcase
        end
        FUNC_LOAD_COLOUR: colour_r <= in_tdata[75:52];
        default: ;
      endcase
    end
  end

  stps_edge u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .meta_in  (meta_in),
    .vert     (vert_r),
    .px       (in_px),
    .py       (in_py),
    .meta_out (e_meta),
    .cov      (e_cov),
    .mag_e    (e_mag),
    .mag_area (e_area),
    .z_out    (e_z)
  );

  stps_interp u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .meta_in  (e_meta),
    .cov_in   (e_cov),
    .mag_e    (e_mag),
    .mag_area (e_area),
    .z_in     (e_z),
    .meta_out (d_meta),
    .cov_out  (d_cov),
    .quot     (d_quot)
  );

  always_comb begin
    total_nxt = '0;
    count_nxt = '0;
    for (int s = 0; s < NSAMP; s++) begin
      if (d_cov[s]) begin
        total_nxt = total_nxt + TW'(d_quot[s]);
        count_nxt = count_nxt + 3'd1;
      end
    end
  end

  always_comb begin
    case (count2_r)
      3'd1:    avg_nxt = ZW'(total2_r);
      3'd2:    avg_nxt = ZW'(total2_r >> 1);
      3'd3:    avg_nxt = ZW'(prod3_r >> DIV3_SHIFT);
      3'd4:    avg_nxt = ZW'(total2_r >> 2);
      default: avg_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      total1_r <= total_nxt;
      count1_r <= count_nxt;
      total2_r <= total1_r;
      count2_r <= count1_r;
      prod3_r  <= total1_r * DIV3_RECIP;
      avg3_r   <= avg_nxt;
      count3_r <= count2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta1_r <= '0;
      meta2_r <= '0;
      meta3_r <= '0;
    end else if (en) begin
      meta1_r <= d_meta;
      meta2_r <= meta1_r;
      meta3_r <= meta2_r;
    end
  end

  // The store is read as a request moves into the test stage; a write made
  // on that same edge is not in the read data, so the bypass supplies it.
  assign old_depth = (byp_valid_r && (byp_addr_r == meta3_r.idx)) ? byp_data_r : ram_rdata;
  assign pass      = (meta3_r.func == FUNC_SHADE) && (count3_r != 3'd0)
                     && (avg3_r < old_depth);
  assign wr_req    = meta3_r.valid && ((meta3_r.func == FUNC_CLEAR) || pass);
  assign wr_en     = en && wr_req;
  assign wr_data   = (meta3_r.func == FUNC_CLEAR) ? DEPTH_MAX : avg3_r;

  stps_ram #(
    .WIDTH (ZW),
    .DEPTH (STORE_DEPTH)
  ) u_depth_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (meta3_r.idx),
    .wdata (wr_data),
    .re    (en),
    .raddr (meta2_r.idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_valid_r <= 1'b0;
    end else if (en) begin
      byp_valid_r <= wr_req;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byp_addr_r <= meta3_r.idx;
      byp_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= meta3_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_write_r  <= pass;
      out_colour_r <= pass ? meta3_r.colour : '0;
      if (meta3_r.func == FUNC_SHADE) begin
        out_idx_r   <= meta3_r.idx;
        out_depth_r <= avg3_r;
        out_count_r <= count3_r;
      end else begin
        out_idx_r   <= '0;
        out_depth_r <= '0;
        out_count_r <= '0;
      end
    end
  end

  // The colour register holds red in its low byte and blue in its high byte.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_write_r;
  assign out_tdata  = {5'b00000, out_count_r, out_depth_r,
                       out_colour_r[23:16], out_colour_r[15:8], out_colour_r[7:0],
                       out_idx_r};

endmodule

// ===== sv/stps_checker.sv =====
// Port-level checks of the triangle pixel shader, bound to its top level.
// Depends on supersampled_triangle_pixel_shader_unit_macros.svh.
`include "supersampled_triangle_pixel_shader_unit_macros.svh"

module stps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [0:0]  out_tuser
);

  `STPS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `STPS_ASSERT_IMP(a_stall_blocks_in, out_tvalid && !out_tready, !in_tready, "request taken while the pipeline is frozen")
  `STPS_ASSERT_IMP(a_write_needs_cover, out_tvalid && out_tuser[0], out_tdata[58:56] != 3'd0, "pixel write without a covered sample")
  `STPS_ASSERT_IMP(a_colour_only_on_write, out_tvalid && !out_tuser[0], out_tdata[39:16] == 24'd0, "colour shown without a pixel write")
  `STPS_ASSERT_IMP(a_count_range, out_tvalid, !(out_tdata[58] && (out_tdata[57:56] != 2'd0)), "covered count above four")

endmodule

bind supersampled_triangle_pixel_shader_unit stps_checker u_stps_checker (.*);
